FILE: hw/rtl/unique_value_set_table_core_assert.svh
// assertion helpers for the set table checker
// both macros sample on clk and are disabled while arst_n is low
`ifndef UNIQUE_VALUE_SET_TABLE_CORE_ASSERT_SVH
`define UNIQUE_VALUE_SET_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define UVST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uvst check failed");

// next-cycle implication
`define UVST_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uvst check failed");

`endif

FILE: hw/rtl/uvst_pkg.sv
package uvst_pkg;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// width of the reported count
	localparam int unsigned HELD_W = 5;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic              ok;
		logic              table_full;
		logic [HELD_W-1:0] entries_held;
	} rsp_item_t;

endpackage

FILE: hw/rtl/unique_value_set_table_core.sv
// set of distinct signed 32-bit values held in CAPACITY table entries
// command channel: cmd_valid / cmd_stall carry one item (command, value);
//   the item is taken at a clock edge with cmd_valid high and cmd_stall low
//   commands: insert if absent, remove if present, membership lookup
// response channel: rsp_valid / rsp_stall carry one item per command
//   (ok, table_full, entries_held), in command order
// the taken item waits in the input stage, and its result is registered
//   in the response register that drives rsp_valid and rsp
// throughput: one item per cycle while cmd_stall is low; every entry
//   is compared in parallel and the table is written at the end of the
//   same cycle, so the next item sees the updated contents
// reset: all entries become empty, the count goes to zero, both stages empty
// when rsp_stall holds a response, one more item may wait in the input
//   stage; cmd_stall then rises until the response is taken
module unique_value_set_table_core #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  uvst_pkg::cmd_item_t  cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output uvst_pkg::rsp_item_t  rsp
);

	logic                valid_s1;
	uvst_pkg::cmd_item_t item_s1;
	logic                rsp_valid_q;
	uvst_pkg::rsp_item_t rsp_q;
	uvst_pkg::rsp_item_t result;
	logic                advance;
	logic                accept;

	// handshake
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign accept    = cmd_valid && !cmd_stall;

	// table with compare, allocate and update
	uvst_table #(
		.CAPACITY(CAPACITY)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.result (result)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hw/rtl/uvst_table.sv
module uvst_table #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  uvst_pkg::cmd_item_t  item,
	output uvst_pkg::rsp_item_t  result
);

	localparam int unsigned CntW = $clog2(CAPACITY + 1);

	logic [31:0]         value_q [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CntW-1:0]     count_q;

	logic [CAPACITY-1:0] hit_vec;
	logic [CAPACITY-1:0] free_vec;
	logic [CAPACITY-1:0] free_oh;
	logic                hit;
	logic                full;
	logic                is_ins;
	logic                is_rem;
	logic                is_look;
	logic                do_ins;
	logic                do_rem;
	logic [CntW-1:0]     count_next;

	// parallel compare against every valid entry
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit_vec[i] = valid_q[i] && (value_q[i] == item.value);
		end
	end

	assign hit      = |hit_vec;
	assign full     = &valid_q;
	assign free_vec = ~valid_q;
	// lowest free entry as a one-hot vector
	assign free_oh  = free_vec & (~free_vec + CAPACITY'(1));

	assign is_ins  = (item.command == uvst_pkg::CMD_INSERT);
	assign is_rem  = (item.command == uvst_pkg::CMD_REMOVE);
	assign is_look = (item.command == uvst_pkg::CMD_LOOKUP);

	assign do_ins = go && is_ins && !hit && !full;
	assign do_rem = go && is_rem && hit;

	// count after this item
	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CntW'(1);
		end else if (do_rem) begin
			count_next = count_q - CntW'(1);
		end
	end

	// result of the item
	assign result.ok           = (is_ins && !hit && !full) || ((is_rem || is_look) && hit);
	assign result.table_full   = is_ins && !hit && full;
	assign result.entries_held = uvst_pkg::HELD_W'(count_next);

	// entry values, written into the lowest free entry
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_ins && free_oh[i]) begin
				value_q[i] <= item.value;
			end
		end
	end

	// valid bits and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else begin
			if (do_ins) begin
				valid_q <= valid_q | free_oh;
			end else if (do_rem) begin
				valid_q <= valid_q & ~hit_vec;
			end
			count_q <= count_next;
		end
	end

endmodule

FILE: hw/rtl/uvst_checker.sv
`include "unique_value_set_table_core_assert.svh"

module uvst_checker #(
	parameter int unsigned CAPACITY = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input uvst_pkg::cmd_item_t cmd,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input uvst_pkg::rsp_item_t rsp
);

	// a held response keeps its item
	`UVST_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// a failed insert into a full table never reports success
	`UVST_ASSERT_IMP(a_full_not_ok, rsp_valid && rsp.table_full, !rsp.ok)

	// full flag only with every entry in use
	`UVST_ASSERT_IMP(a_full_count, rsp_valid && rsp.table_full,
		(CAPACITY > 31) || (rsp.entries_held == CAPACITY))

	// a fresh response follows an item taken through the input stage and response register
	`UVST_ASSERT_IMP(a_rsp_origin, $rose(rsp_valid),
		$past(cmd_valid && !cmd_stall && (cmd == cmd), 2))

endmodule

bind unique_value_set_table_core uvst_checker #(.CAPACITY(CAPACITY)) u_uvst_checker (.*);
